// ===== design/lpr_pkg.sv =====
// shared types, constants and helpers for the line pixel rasterizer
`default_nettype none

package lpr_pkg;

    localparam int COORD_W     = 6;
    localparam int COLOR_W     = 8;
    localparam int GRID_WIDTH  = 64;
    localparam int GRID_HEIGHT = 64;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [COLOR_W-1:0] color_t;

    typedef struct packed {
        coord_t quotient;
        coord_t remainder;
    } div_result_t;

    function automatic coord_t clamp_row(input coord_t v);
        coord_t r;
        r = v;
        if (int'(v) > GRID_HEIGHT - 1)
        begin
            r = COORD_W'(GRID_HEIGHT - 1);
        end
        return r;
    endfunction

    function automatic coord_t clamp_col(input coord_t v);
        coord_t r;
        r = v;
        if (int'(v) > GRID_WIDTH - 1)
        begin
            r = COORD_W'(GRID_WIDTH - 1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/lpr_div.sv =====
// iterative restoring divider, one quotient bit per cycle
`default_nettype none

module lpr_div
    import lpr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire coord_t      dividend,
    input  wire coord_t      divisor,
    output logic             done,
    output div_result_t      result
);

    localparam int CNT_W = $clog2(COORD_W);

    typedef enum logic {
        D_IDLE,
        D_RUN
    } div_state_t;

    div_state_t         state_reg;
    logic [CNT_W-1:0]   cnt_reg;
    coord_t             rem_reg;
    coord_t             quo_reg;
    coord_t             dvs_reg;
    logic               done_reg;

    logic [COORD_W:0]   rem_shift;
    logic [COORD_W:0]   rem_diff;
    logic               fits;

    assign rem_shift = {rem_reg, quo_reg[COORD_W-1]};
    assign rem_diff  = rem_shift - {1'b0, dvs_reg};
    assign fits      = rem_shift >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            rem_reg   <= '0;
            quo_reg   <= '0;
            dvs_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        rem_reg   <= '0;
                        quo_reg   <= dividend;
                        dvs_reg   <= divisor;
                        cnt_reg   <= '0;
                        state_reg <= D_RUN;
                    end
                end
                D_RUN:
                begin
                    rem_reg <= fits ? rem_diff[COORD_W-1:0] : rem_shift[COORD_W-1:0];
                    quo_reg <= {quo_reg[COORD_W-2:0], fits};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(COORD_W - 1))
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign done             = done_reg;
    assign result.quotient  = quo_reg;
    assign result.remainder = rem_reg;

endmodule

`default_nettype wire

// ===== design/line_pixel_rasterizer.sv =====
// line pixel rasterizer top level: endpoint setup, pixel stepping and output register
//
// A transaction is taken when start is high and busy is low; busy then stays high
// until the last pixel of the run has been issued. Pixels come out one per cycle on
// valid, with last marking the final one, and must be taken when shown. A line whose
// columns differ first passes through the divider (one quotient bit per cycle, row
// difference over column span) and then steps through its pixels in the accumulate
// unit. A vertical line skips the divider. Identical endpoints give no pixels and
// leave busy low.
`default_nettype none

module line_pixel_rasterizer
    import lpr_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   start,
    output logic        busy,
    input  wire coord_t first_row,
    input  wire coord_t first_col,
    input  wire coord_t second_row,
    input  wire coord_t second_col,
    input  wire color_t color,
    output logic        valid,
    output coord_t      pixel_row,
    output coord_t      pixel_col,
    output color_t      pixel_color,
    output logic        last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_RUN
    } state_t;

    state_t         state_reg;
    logic           vert_reg;
    logic           neg_reg;
    coord_t         near_r_reg;
    coord_t         col_reg;
    coord_t         row_reg;
    coord_t         end_reg;
    coord_t         span_reg;
    coord_t         quo_reg;
    coord_t         rem_reg;
    coord_t         acc_reg;
    logic [COORD_W:0] q_reg;
    color_t         color_reg;

    logic           valid_reg;
    coord_t         prow_reg;
    coord_t         pcol_reg;
    color_t         pcolor_reg;
    logic           last_reg;

    coord_t         r1;
    coord_t         c1;
    coord_t         r2;
    coord_t         c2;
    coord_t         far_r;
    coord_t         far_c;
    coord_t         near_r;
    coord_t         near_c;
    coord_t         span;
    logic           neg;
    coord_t         drow_mag;
    coord_t         lo_r;
    coord_t         hi_r;
    logic           accept;

    logic           div_done;
    div_result_t    div_res;

    logic [COORD_W:0] acc_sum;
    logic             acc_wrap;
    coord_t           step_row;
    logic             run_last;

    assign accept = start && !busy;

    always_comb
    begin
        r1 = clamp_row(first_row);
        c1 = clamp_col(first_col);
        r2 = clamp_row(second_row);
        c2 = clamp_col(second_col);
        if (c1 >= c2)
        begin
            far_r  = r1;
            far_c  = c1;
            near_r = r2;
            near_c = c2;
        end
        else
        begin
            far_r  = r2;
            far_c  = c2;
            near_r = r1;
            near_c = c1;
        end
        span     = far_c - near_c;
        neg      = far_r < near_r;
        drow_mag = neg ? (near_r - far_r) : (far_r - near_r);
        lo_r     = (r1 < r2) ? r1 : r2;
        hi_r     = (r1 < r2) ? r2 : r1;
    end

    lpr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept && (span != '0)),
        .dividend (drow_mag),
        .divisor  (span),
        .done     (div_done),
        .result   (div_res)
    );

    // accumulate unit: remainder accumulates and wraps once it reaches the span
    assign acc_sum  = {1'b0, acc_reg} + {1'b0, rem_reg};
    assign acc_wrap = acc_sum >= {1'b0, span_reg};
    assign step_row = neg_reg ? (near_r_reg - q_reg[COORD_W-1:0])
                              : (near_r_reg + q_reg[COORD_W-1:0]);
    assign run_last = vert_reg ? (row_reg == end_reg - 1'b1) : (col_reg == end_reg - 1'b1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            valid_reg  <= 1'b0;
            last_reg   <= 1'b0;
            vert_reg   <= 1'b0;
            neg_reg    <= 1'b0;
            near_r_reg <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            end_reg    <= '0;
            span_reg   <= '0;
            quo_reg    <= '0;
            rem_reg    <= '0;
            acc_reg    <= '0;
            q_reg      <= '0;
            color_reg  <= '0;
            prow_reg   <= '0;
            pcol_reg   <= '0;
            pcolor_reg <= '0;
        end
        else
        begin
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        color_reg  <= color;
                        neg_reg    <= neg;
                        near_r_reg <= near_r;
                        span_reg   <= span;
                        acc_reg    <= '0;
                        q_reg      <= '0;
                        if (span != '0)
                        begin
                            vert_reg  <= 1'b0;
                            col_reg   <= near_c;
                            end_reg   <= far_c;
                            state_reg <= S_DIV;
                        end
                        else if (lo_r != hi_r)
                        begin
                            vert_reg  <= 1'b1;
                            col_reg   <= near_c;
                            row_reg   <= lo_r;
                            end_reg   <= hi_r;
                            state_reg <= S_RUN;
                        end
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        quo_reg   <= div_res.quotient;
                        rem_reg   <= div_res.remainder;
                        state_reg <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    valid_reg  <= 1'b1;
                    last_reg   <= run_last;
                    pcol_reg   <= col_reg;
                    pcolor_reg <= color_reg;
                    if (vert_reg)
                    begin
                        prow_reg <= row_reg;
                        row_reg  <= row_reg + 1'b1;
                    end
                    else
                    begin
                        prow_reg <= step_row;
                        col_reg  <= col_reg + 1'b1;
                        if (acc_wrap)
                        begin
                            acc_reg <= COORD_W'(acc_sum - {1'b0, span_reg});
                            q_reg   <= q_reg + {1'b0, quo_reg} + 1'b1;
                        end
                        else
                        begin
                            acc_reg <= acc_sum[COORD_W-1:0];
                            q_reg   <= q_reg + {1'b0, quo_reg};
                        end
                    end
                    if (run_last)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy        = state_reg != S_IDLE;
    assign valid       = valid_reg;
    assign pixel_row   = prow_reg;
    assign pixel_col   = pcol_reg;
    assign pixel_color = pcolor_reg;
    assign last        = last_reg;

    // a pixel only follows a cycle of work
    assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> $past(busy))
        else $error("pixel issued without a line in progress");

    // the final pixel closes the run
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && last |-> !busy)
        else $error("still busy after the final pixel");

    // identical endpoints give nothing
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && first_row == second_row && first_col == second_col |=> !busy && !valid)
        else $error("pixels issued for a degenerate line");

    // divider only finishes while waiting for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider result outside the divide phase");

endmodule

`default_nettype wire

// ===== tb/line_pixel_rasterizer_tb.sv =====
// testbench for the line pixel rasterizer: directed and random lines checked pixel by pixel
`timescale 1ns / 1ps

module line_pixel_rasterizer_tb;
    import lpr_pkg::*;

    typedef struct {
        coord_t row;
        coord_t col;
        color_t hue;
        logic   last;
    } pixel_t;

    logic   clk;
    logic   rst_n;
    logic   start;
    logic   busy;
    coord_t first_row;
    coord_t first_col;
    coord_t second_row;
    coord_t second_col;
    color_t color;
    logic   valid;
    coord_t pixel_row;
    coord_t pixel_col;
    color_t pixel_color;
    logic   last;

    pixel_t expected_pixels[$];
    int     mismatch_count;
    bit     gaps_enabled;

    line_pixel_rasterizer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .first_row   (first_row),
        .first_col   (first_col),
        .second_row  (second_row),
        .second_col  (second_col),
        .color       (color),
        .valid       (valid),
        .pixel_row   (pixel_row),
        .pixel_col   (pixel_col),
        .pixel_color (pixel_color),
        .last        (last)
    );

    always #1 clk = ~clk;

    function automatic int clip(input coord_t v, input int size);
        int r;
        r = int'(v);
        if (r > size - 1)
        begin
            r = size - 1;
        end
        return r;
    endfunction

    // expected pixels of one line, appended in stepping order
    function automatic void rasterize_line(input coord_t r1_in, input coord_t c1_in,
                                           input coord_t r2_in, input coord_t c2_in,
                                           input color_t hue);
        int r1;
        int c1;
        int r2;
        int c2;
        int far_r;
        int far_c;
        int near_r;
        int near_c;
        int span;
        int drow;
        int lo;
        int hi;
        int idx;
        pixel_t px;
        r1 = clip(r1_in, GRID_HEIGHT);
        c1 = clip(c1_in, GRID_WIDTH);
        r2 = clip(r2_in, GRID_HEIGHT);
        c2 = clip(c2_in, GRID_WIDTH);
        px.hue = hue;
        if (c1 >= c2)
        begin
            far_r = r1;
            far_c = c1;
            near_r = r2;
            near_c = c2;
        end
        else
        begin
            far_r = r2;
            far_c = c2;
            near_r = r1;
            near_c = c1;
        end
        if (far_c > near_c)
        begin
            span = far_c - near_c;
            drow = far_r - near_r;
            for (idx = near_c; idx < far_c; idx++)
            begin
                px.row  = coord_t'(near_r + (drow * (idx - near_c)) / span);
                px.col  = coord_t'(idx);
                px.last = (idx == far_c - 1);
                expected_pixels.push_back(px);
            end
        end
        else
        begin
            lo = (r1 < r2) ? r1 : r2;
            hi = (r1 < r2) ? r2 : r1;
            for (idx = lo; idx < hi; idx++)
            begin
                px.row  = coord_t'(idx);
                px.col  = coord_t'(near_c);
                px.last = (idx == hi - 1);
                expected_pixels.push_back(px);
            end
        end
    endfunction

    // start stays high from one transaction to the next; idle_cycles or drain lowers it
    task automatic send_line(input coord_t r1, input coord_t c1, input coord_t r2,
                             input coord_t c2, input color_t hue);
        @(negedge clk);
        start      = 1'b1;
        first_row  = r1;
        first_col  = c1;
        second_row = r2;
        second_col = c2;
        color      = hue;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        rasterize_line(r1, c1, r2, c2, hue);
    endtask

    task automatic idle_cycles(input int n);
        repeat (n)
        begin
            @(negedge clk);
            start      = 1'b0;
            first_row  = coord_t'($urandom);
            first_col  = coord_t'($urandom);
            second_row = coord_t'($urandom);
            second_col = coord_t'($urandom);
            color      = color_t'($urandom);
        end
    endtask

    task automatic drain;
        idle_cycles(1);
        while (expected_pixels.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_random_line;
        coord_t r1;
        coord_t c1;
        coord_t r2;
        coord_t c2;
        int kind;
        if (gaps_enabled && $urandom_range(0, 3) == 0)
        begin
            idle_cycles($urandom_range(1, 17));
        end
        kind = $urandom_range(0, 9);
        r1 = coord_t'($urandom);
        c1 = coord_t'($urandom);
        r2 = coord_t'($urandom);
        c2 = coord_t'($urandom);
        case (kind)
            0:
            begin
                r2 = r1;
                c2 = c1;
            end
            1, 2:
            begin
                c2 = c1;
            end
            3, 4:
            begin
                c2 = coord_t'(c1 + $urandom_range(1, 4));
            end
            default:
            begin
            end
        endcase
        send_line(r1, c1, r2, c2, color_t'($urandom));
    endtask

    task automatic test_diagonals;
        send_line(6'd0, 6'd0, 6'd63, 6'd63, 8'h00);
        send_line(6'd63, 6'd63, 6'd0, 6'd0, 8'hff);
        send_line(6'd0, 6'd63, 6'd63, 6'd0, 8'h55);
        send_line(6'd63, 6'd0, 6'd0, 6'd63, 8'haa);
        send_line(6'd40, 6'd3, 6'd0, 6'd10, 8'h01);
        send_line(6'd0, 6'd10, 6'd40, 6'd3, 8'h80);
        send_line(6'd0, 6'd0, 6'd63, 6'd1, 8'h7f);
    endtask

    task automatic test_horizontal;
        send_line(6'd5, 6'd0, 6'd5, 6'd63, 8'h3c);
        send_line(6'd63, 6'd63, 6'd63, 6'd0, 8'hc3);
        send_line(6'd0, 6'd17, 6'd0, 6'd18, 8'h0f);
    endtask

    task automatic test_vertical;
        send_line(6'd0, 6'd10, 6'd63, 6'd10, 8'hf0);
        send_line(6'd63, 6'd10, 6'd0, 6'd10, 8'h12);
        send_line(6'd20, 6'd0, 6'd21, 6'd0, 8'h34);
        send_line(6'd63, 6'd63, 6'd62, 6'd63, 8'h56);
    endtask

    task automatic test_identical;
        send_line(6'd0, 6'd0, 6'd0, 6'd0, 8'h00);
        send_line(6'd63, 6'd63, 6'd63, 6'd63, 8'hff);
        send_line(6'd31, 6'd17, 6'd31, 6'd17, 8'h99);
        send_line(6'd1, 6'd2, 6'd3, 6'd4, 8'h66);
    endtask

    task automatic test_random_with_gaps;
        gaps_enabled = 1'b1;
        repeat (80)
        begin
            send_random_line();
        end
    endtask

    task automatic test_drain_then_resume;
        drain();
        repeat (40)
        begin
            send_random_line();
        end
        drain();
    endtask

    task automatic test_random_back_to_back;
        gaps_enabled = 1'b0;
        repeat (80)
        begin
            send_random_line();
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && valid)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("unexpected pixel row %0d col %0d", pixel_row, pixel_col);
                mismatch_count++;
            end
            else
            begin
                if (pixel_row !== expected_pixels[0].row)
                begin
                    $error("pixel_row: expected %0d, actual %0d",
                           expected_pixels[0].row, pixel_row);
                    mismatch_count++;
                end
                if (pixel_col !== expected_pixels[0].col)
                begin
                    $error("pixel_col: expected %0d, actual %0d",
                           expected_pixels[0].col, pixel_col);
                    mismatch_count++;
                end
                if (pixel_color !== expected_pixels[0].hue)
                begin
                    $error("pixel_color: expected %0d, actual %0d",
                           expected_pixels[0].hue, pixel_color);
                    mismatch_count++;
                end
                if (last !== expected_pixels[0].last)
                begin
                    $error("last: expected %0d, actual %0d", expected_pixels[0].last, last);
                    mismatch_count++;
                end
                void'(expected_pixels.pop_front());
            end
        end
    end

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        start          = 1'b0;
        first_row      = '0;
        first_col      = '0;
        second_row     = '0;
        second_col     = '0;
        color          = '0;
        mismatch_count = 0;
        gaps_enabled   = 1'b0;
        repeat (5)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        rst_n = 1'b1;

        test_diagonals();
        test_horizontal();
        test_vertical();
        test_identical();
        test_random_with_gaps();
        test_drain_then_resume();
        test_random_back_to_back();

        drain();
        repeat (80)
        begin
            @(posedge clk);
        end
        if (mismatch_count == 0 && expected_pixels.size() == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
